/* design/cpc_pkg.sv */
package cpc_pkg;

    localparam int IDX_W = 4;
    localparam int CNT_W = 5;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_CLIP = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] CORNER_B    = 2'd1;
    localparam logic [1:0] CORNER_C    = 2'd2;
    localparam logic [1:0] CORNER_NONE = 2'd3;

    localparam logic [4:0] DIST_LAST = 5'd4;
    localparam logic [4:0] DIV_LAST  = 5'd16;
    localparam logic [4:0] MIX_LAST  = 5'd5;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DIST,
        S_DECIDE,
        S_WALK,
        S_FETCH_A,
        S_FETCH_B,
        S_DIV_INIT,
        S_DIV_STEP,
        S_MIX,
        S_WRITE_CUT,
        S_COMMIT,
        S_STATUS,
        S_READ
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_DIST,
        OP_EMPTY,
        OP_WALK_INIT,
        OP_COPY,
        OP_FETCH_A,
        OP_FETCH_B,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MIX,
        OP_WRITE_CUT,
        OP_COMMIT,
        OP_EMIT_STATUS,
        OP_EMIT_VERTEX
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [4:0]       step;
        logic             flag;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] size;
        logic [CNT_W-1:0] outs;
        logic             cur_out;
        logic             prv_out;
        logic             nxt_out;
    } t_stat;

endpackage

/* design/cpc_ctrl.sv */
module cpc_ctrl import cpc_pkg::*; #(
    parameter int MAX_VERTICES = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_mode,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [4:0]       r_k, n_k;
    logic [IDX_W-1:0] r_ia, n_ia;
    logic [IDX_W-1:0] r_ib, n_ib;
    logic             r_pend, n_pend;
    logic             r_zero, n_zero;

    logic [CNT_W-1:0] sz_m1;
    logic             last_i;
    logic [IDX_W-1:0] prv_idx;
    logic [IDX_W-1:0] nxt_idx;
    logic             gate;

    assign sz_m1   = i_stat.size - CNT_W'(1);
    assign last_i  = ({1'b0, r_i} == sz_m1);
    assign prv_idx = (r_i == '0) ? sz_m1[IDX_W-1:0] : r_i - IDX_W'(1);
    assign nxt_idx = last_i ? '0 : r_i + IDX_W'(1);
    assign gate    = (i_stat.size >= CNT_W'(3)) && (i_stat.size < CNT_W'(MAX_VERTICES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_k     <= '0;
            r_ia    <= '0;
            r_ib    <= '0;
            r_pend  <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_k     <= n_k;
            r_ia    <= n_ia;
            r_ib    <= n_ib;
            r_pend  <= n_pend;
            r_zero  <= n_zero;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_k     = r_k;
        n_ia    = r_ia;
        n_ib    = r_ib;
        n_pend  = r_pend;
        n_zero  = r_zero;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_i = '0;
                    n_k = '0;
                    if (i_mode == MODE_LOAD) begin
                        n_state = S_LOAD;
                    end else if (i_mode == MODE_CLIP && gate) begin
                        n_state = S_DIST;
                    end else if (i_mode == MODE_READ && i_stat.size != '0) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_STATUS;
                    end
                end
            end
            S_LOAD: n_state = S_STATUS;
            S_DIST: begin
                if (r_k == DIST_LAST) begin
                    n_k = '0;
                    if (last_i) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_i = r_i + IDX_W'(1);
                    end
                end else begin
                    n_k = r_k + 5'd1;
                end
            end
            S_DECIDE: begin
                if (i_stat.outs == '0 || i_stat.outs >= i_stat.size) begin
                    n_state = S_STATUS;
                end else begin
                    n_i     = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.cur_out && !i_stat.prv_out) begin
                    n_ia    = prv_idx;
                    n_ib    = r_i;
                    n_zero  = 1'b0;
                    n_pend  = (i_stat.outs == CNT_W'(1));
                    n_state = S_FETCH_A;
                end else if (i_stat.cur_out && !i_stat.nxt_out) begin
                    n_ia    = r_i;
                    n_ib    = nxt_idx;
                    n_zero  = 1'b0;
                    n_pend  = 1'b0;
                    n_state = S_FETCH_A;
                end else if (last_i) begin
                    n_state = S_COMMIT;
                end else begin
                    n_i = r_i + IDX_W'(1);
                end
            end
            S_FETCH_A: n_state = S_FETCH_B;
            S_FETCH_B: n_state = S_DIV_INIT;
            S_DIV_INIT: begin
                n_k     = '0;
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                if (r_k == DIV_LAST) begin
                    n_k     = '0;
                    n_state = S_MIX;
                end else begin
                    n_k = r_k + 5'd1;
                end
            end
            S_MIX: begin
                if (r_k == MIX_LAST) begin
                    n_k     = '0;
                    n_state = S_WRITE_CUT;
                end else begin
                    n_k = r_k + 5'd1;
                end
            end
            S_WRITE_CUT: begin
                if (r_pend) begin
                    n_ia    = r_i;
                    n_ib    = nxt_idx;
                    n_zero  = last_i;
                    n_pend  = 1'b0;
                    n_state = S_FETCH_A;
                end else if (last_i) begin
                    n_state = S_COMMIT;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_WALK;
                end
            end
            S_COMMIT: n_state = S_STATUS;
            S_STATUS: n_state = S_IDLE;
            S_READ: begin
                if (last_i) begin
                    n_state = S_IDLE;
                end else begin
                    n_i = r_i + IDX_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.idx  = r_i;
        o_cmd.step = r_k;
        o_cmd.flag = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LATCH;
                end
            end
            S_LOAD: o_cmd.op = OP_LOAD;
            S_DIST: o_cmd.op = OP_DIST;
            S_DECIDE: begin
                if (i_stat.outs != '0 && i_stat.outs >= i_stat.size) begin
                    o_cmd.op = OP_EMPTY;
                end else if (i_stat.outs != '0) begin
                    o_cmd.op = OP_WALK_INIT;
                end
            end
            S_WALK: begin
                if (!i_stat.cur_out) begin
                    o_cmd.op = OP_COPY;
                end
            end
            S_FETCH_A: begin
                o_cmd.op  = OP_FETCH_A;
                o_cmd.idx = r_ia;
            end
            S_FETCH_B: begin
                o_cmd.op  = OP_FETCH_B;
                o_cmd.idx = r_ib;
            end
            S_DIV_INIT: o_cmd.op = OP_DIV_INIT;
            S_DIV_STEP: o_cmd.op = OP_DIV_STEP;
            S_MIX:      o_cmd.op = OP_MIX;
            S_WRITE_CUT: begin
                o_cmd.op   = OP_WRITE_CUT;
                o_cmd.flag = r_zero;
            end
            S_COMMIT: o_cmd.op = OP_COMMIT;
            S_STATUS: o_cmd.op = OP_EMIT_STATUS;
            S_READ: begin
                o_cmd.op   = OP_EMIT_VERTEX;
                o_cmd.flag = last_i;
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_start) |=> (r_state == S_IDLE))
        else $error("controller left idle without start");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_STEP) |-> (r_k <= DIV_LAST))
        else $error("divider step count overran");

    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ({1'b0, r_i} < i_stat.size))
        else $error("readout index beyond polygon size");

endmodule

/* design/cpc_dpath.sv */
module cpc_dpath import cpc_pkg::*; #(
    parameter int MAX_VERTICES = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [1:0]         i_corner_index,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_normal_x,
    input  logic signed [31:0] i_normal_y,
    input  logic signed [31:0] i_normal_z,
    input  logic signed [31:0] i_plane_offset,
    output t_stat              o_stat,
    output logic               o_valid,
    output logic [3:0]         o_vertex_index,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic [16:0]        o_weight_b,
    output logic [16:0]        o_weight_c,
    output logic [3:0]         o_vertex_count,
    output logic               o_last
);

    localparam int IW = $clog2(MAX_VERTICES);

    logic signed [31:0] r_bx  [2][MAX_VERTICES];
    logic signed [31:0] r_by  [2][MAX_VERTICES];
    logic signed [31:0] r_bz  [2][MAX_VERTICES];
    logic [16:0]        r_bwb [2][MAX_VERTICES];
    logic [16:0]        r_bwc [2][MAX_VERTICES];
    logic signed [31:0] r_dist [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_out;

    logic               r_bank;
    logic [CNT_W-1:0]   r_size;
    logic [CNT_W-1:0]   r_wp;
    logic [CNT_W-1:0]   r_outs;

    logic [1:0]         r_corner;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [31:0] r_nx, r_ny, r_nz, r_off;

    logic signed [31:0] r_ax, r_ay, r_az, r_bx_h, r_by_h, r_bz_h;
    logic [16:0]        r_awb, r_awc, r_bwb_h, r_bwc_h;
    logic signed [31:0] r_da, r_db;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [16:0]        r_cwb, r_cwc;

    logic signed [67:0] r_prod;
    logic signed [65:0] r_acc;

    logic [32:0]        r_rem;
    logic [32:0]        r_den;
    logic [16:0]        r_nlo;
    logic [16:0]        r_q;
    logic               r_fix;

    logic               r_valid;
    logic [3:0]         r_o_idx;
    logic signed [31:0] r_o_x, r_o_y, r_o_z;
    logic [16:0]        r_o_wb, r_o_wc;
    logic               r_o_last;

    logic [IW-1:0]      rd_idx;
    logic signed [31:0] rd_x, rd_y, rd_z;
    logic [16:0]        rd_wb, rd_wc;
    logic [CNT_W-1:0]   sz_m1;
    logic [IW-1:0]      prv_idx, nxt_idx;

    logic               wr_en;
    logic               wr_bank;
    logic [IW-1:0]      wr_addr;
    logic signed [31:0] wr_x, wr_y, wr_z;
    logic [16:0]        wr_wb, wr_wc;

    logic signed [33:0] mul_a, mul_b;
    logic signed [65:0] dist_full;
    logic signed [31:0] dist_sat;

    logic signed [33:0] num0, den0, num1, den1;
    logic [49:0]        n_big;
    logic [33:0]        rem_sh;

    logic signed [67:0] mix_rnd;
    logic signed [67:0] mix_sh;
    logic signed [33:0] mix_a;
    logic signed [33:0] mix_val;

    assign rd_idx  = i_cmd.idx[IW-1:0];
    assign rd_x    = r_bx[r_bank][rd_idx];
    assign rd_y    = r_by[r_bank][rd_idx];
    assign rd_z    = r_bz[r_bank][rd_idx];
    assign rd_wb   = r_bwb[r_bank][rd_idx];
    assign rd_wc   = r_bwc[r_bank][rd_idx];
    assign sz_m1   = r_size - CNT_W'(1);
    assign prv_idx = (rd_idx == '0) ? sz_m1[IW-1:0] : rd_idx - IW'(1);
    assign nxt_idx = ({1'b0, i_cmd.idx} == sz_m1) ? '0 : rd_idx + IW'(1);

    assign o_stat.size    = r_size;
    assign o_stat.outs    = r_outs;
    assign o_stat.cur_out = r_out[rd_idx];
    assign o_stat.prv_out = r_out[prv_idx];
    assign o_stat.nxt_out = r_out[nxt_idx];

    always_comb begin
        wr_en   = 1'b0;
        wr_bank = ~r_bank;
        wr_addr = r_wp[IW-1:0];
        wr_x    = rd_x;
        wr_y    = rd_y;
        wr_z    = rd_z;
        wr_wb   = rd_wb;
        wr_wc   = rd_wc;
        case (i_cmd.op)
            OP_LOAD: begin
                wr_en   = (r_corner != CORNER_NONE);
                wr_bank = r_bank;
                wr_addr = IW'(r_corner);
                wr_x    = r_px;
                wr_y    = r_py;
                wr_z    = r_pz;
                wr_wb   = (r_corner == CORNER_B) ? ONE_Q16 : '0;
                wr_wc   = (r_corner == CORNER_C) ? ONE_Q16 : '0;
            end
            OP_COPY: wr_en = 1'b1;
            OP_WRITE_CUT: begin
                wr_en   = 1'b1;
                wr_addr = i_cmd.flag ? '0 : r_wp[IW-1:0];
                wr_x    = r_cx;
                wr_y    = r_cy;
                wr_z    = r_cz;
                wr_wb   = r_cwb;
                wr_wc   = r_cwc;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bx[wr_bank][wr_addr]  <= wr_x;
            r_by[wr_bank][wr_addr]  <= wr_y;
            r_bz[wr_bank][wr_addr]  <= wr_z;
            r_bwb[wr_bank][wr_addr] <= wr_wb;
            r_bwc[wr_bank][wr_addr] <= wr_wc;
        end
    end

    always_comb begin
        mul_a = {{2{r_nz[31]}}, r_nz};
        mul_b = {{2{rd_z[31]}}, rd_z};
        if (i_cmd.op == OP_MIX) begin
            mul_b = {17'b0, r_q};
            case (i_cmd.step)
                5'd0:    mul_a = {{2{r_bx_h[31]}}, r_bx_h} - {{2{r_ax[31]}}, r_ax};
                5'd1:    mul_a = {{2{r_by_h[31]}}, r_by_h} - {{2{r_ay[31]}}, r_ay};
                5'd2:    mul_a = {{2{r_bz_h[31]}}, r_bz_h} - {{2{r_az[31]}}, r_az};
                5'd3:    mul_a = {17'b0, r_bwb_h} - {17'b0, r_awb};
                default: mul_a = {17'b0, r_bwc_h} - {17'b0, r_awc};
            endcase
        end else begin
            case (i_cmd.step)
                5'd0: begin
                    mul_a = {{2{r_nx[31]}}, r_nx};
                    mul_b = {{2{rd_x[31]}}, rd_x};
                end
                5'd1: begin
                    mul_a = {{2{r_ny[31]}}, r_ny};
                    mul_b = {{2{rd_y[31]}}, rd_y};
                end
                default: begin
                    mul_a = {{2{r_nz[31]}}, r_nz};
                    mul_b = {{2{rd_z[31]}}, rd_z};
                end
            endcase
        end
    end

    always_comb begin
        dist_full = (r_acc >>> 16) - $signed({{34{r_off[31]}}, r_off});
        if (dist_full > 66'sd2147483647) begin
            dist_sat = 32'sh7fffffff;
        end else if (dist_full < -66'sd2147483648) begin
            dist_sat = 32'sh80000000;
        end else begin
            dist_sat = dist_full[31:0];
        end
    end

    always_comb begin
        num0   = -{{2{r_da[31]}}, r_da};
        den0   = {{2{r_db[31]}}, r_db} - {{2{r_da[31]}}, r_da};
        num1   = (den0 < 0) ? -num0 : num0;
        den1   = (den0 < 0) ? -den0 : den0;
        n_big  = {2'b0, num1[31:0], 16'b0} + {18'b0, den1[32:1]};
        rem_sh = {r_rem, r_nlo[16]};
    end

    always_comb begin
        mix_rnd = r_prod + 68'sd32768;
        mix_sh  = mix_rnd >>> 16;
        case (i_cmd.step)
            5'd1:    mix_a = {{2{r_ax[31]}}, r_ax};
            5'd2:    mix_a = {{2{r_ay[31]}}, r_ay};
            5'd3:    mix_a = {{2{r_az[31]}}, r_az};
            5'd4:    mix_a = {17'b0, r_awb};
            default: mix_a = {17'b0, r_awc};
        endcase
        mix_val = mix_a + mix_sh[33:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.op)
            OP_LATCH: begin
                r_corner <= i_corner_index;
                r_px     <= i_point_x;
                r_py     <= i_point_y;
                r_pz     <= i_point_z;
                r_nx     <= i_normal_x;
                r_ny     <= i_normal_y;
                r_nz     <= i_normal_z;
                r_off    <= i_plane_offset;
            end
            OP_DIST: begin
                if (i_cmd.step == 5'd1) begin
                    r_acc <= r_prod[65:0];
                end else if (i_cmd.step == 5'd2 || i_cmd.step == 5'd3) begin
                    r_acc <= r_acc + r_prod[65:0];
                end else if (i_cmd.step == DIST_LAST) begin
                    r_dist[rd_idx] <= dist_sat;
                    r_out[rd_idx]  <= (dist_sat > 0);
                end
            end
            OP_FETCH_A: begin
                r_ax  <= rd_x;
                r_ay  <= rd_y;
                r_az  <= rd_z;
                r_awb <= rd_wb;
                r_awc <= rd_wc;
                r_da  <= r_dist[rd_idx];
            end
            OP_FETCH_B: begin
                r_bx_h  <= rd_x;
                r_by_h  <= rd_y;
                r_bz_h  <= rd_z;
                r_bwb_h <= rd_wb;
                r_bwc_h <= rd_wc;
                r_db    <= r_dist[rd_idx];
            end
            OP_DIV_INIT: begin
                r_den <= den1[32:0];
                r_rem <= n_big[49:17];
                r_nlo <= n_big[16:0];
                if (den0 == 0) begin
                    r_q   <= HALF_Q16;
                    r_fix <= 1'b1;
                end else if (num1 <= 0) begin
                    r_q   <= '0;
                    r_fix <= 1'b1;
                end else if (num1 >= den1) begin
                    r_q   <= ONE_Q16;
                    r_fix <= 1'b1;
                end else begin
                    r_q   <= '0;
                    r_fix <= 1'b0;
                end
            end
            OP_DIV_STEP: begin
                if (!r_fix) begin
                    r_nlo <= {r_nlo[15:0], 1'b0};
                    if (rem_sh >= {1'b0, r_den}) begin
                        r_rem <= 33'(rem_sh - {1'b0, r_den});
                        r_q   <= {r_q[15:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[32:0];
                        r_q   <= {r_q[15:0], 1'b0};
                    end
                end
            end
            OP_MIX: begin
                case (i_cmd.step)
                    5'd1:    r_cx  <= mix_val[31:0];
                    5'd2:    r_cy  <= mix_val[31:0];
                    5'd3:    r_cz  <= mix_val[31:0];
                    5'd4:    r_cwb <= mix_val[16:0];
                    5'd5:    r_cwc <= mix_val[16:0];
                    default: r_cwc <= r_cwc;
                endcase
            end
            default: r_acc <= r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            r_size <= '0;
            r_wp   <= '0;
            r_outs <= '0;
        end else begin
            case (i_cmd.op)
                OP_LATCH: r_outs <= '0;
                OP_LOAD: begin
                    if (r_corner != CORNER_NONE) begin
                        r_size <= CNT_W'(3);
                    end
                end
                OP_DIST: begin
                    if (i_cmd.step == DIST_LAST && dist_sat > 0) begin
                        r_outs <= r_outs + CNT_W'(1);
                    end
                end
                OP_EMPTY: r_size <= '0;
                OP_WALK_INIT: begin
                    r_wp <= (r_outs == CNT_W'(1) && r_out[sz_m1[IW-1:0]]) ? CNT_W'(1) : '0;
                end
                OP_COPY: r_wp <= r_wp + CNT_W'(1);
                OP_WRITE_CUT: begin
                    if (!i_cmd.flag) begin
                        r_wp <= r_wp + CNT_W'(1);
                    end
                end
                OP_COMMIT: begin
                    r_bank <= ~r_bank;
                    r_size <= r_wp;
                end
                default: r_wp <= r_wp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == OP_EMIT_STATUS) || (i_cmd.op == OP_EMIT_VERTEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT_VERTEX) begin
            r_o_idx  <= i_cmd.idx;
            r_o_x    <= rd_x;
            r_o_y    <= rd_y;
            r_o_z    <= rd_z;
            r_o_wb   <= rd_wb;
            r_o_wc   <= rd_wc;
            r_o_last <= i_cmd.flag;
        end else begin
            r_o_idx  <= '0;
            r_o_x    <= '0;
            r_o_y    <= '0;
            r_o_z    <= '0;
            r_o_wb   <= '0;
            r_o_wc   <= '0;
            r_o_last <= 1'b1;
        end
    end

    assign o_valid        = r_valid;
    assign o_vertex_index = r_o_idx;
    assign o_pos_x        = r_o_x;
    assign o_pos_y        = r_o_y;
    assign o_pos_z        = r_o_z;
    assign o_weight_b     = r_o_wb;
    assign o_weight_c     = r_o_wc;
    assign o_vertex_count = r_size[3:0];
    assign o_last         = r_o_last;

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= CNT_W'(MAX_VERTICES))
        else $error("polygon size exceeds storage");

    a_commit_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_COMMIT) |=> (r_bank != $past(r_bank)))
        else $error("commit did not swap banks");

    a_status_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT_STATUS) |=> (r_valid && r_o_last && r_o_idx == '0))
        else $error("status item malformed");

endmodule

/* design/convex_polygon_plane_clipper.sv */
// Results: a load writes its corner, then its status result is registered; other status results
// are registered from the status state; readout streams one vertex per cycle.
// Clip: distances per vertex on one shared multiplier, then a walk over each vertex, and
// per cut two fetches, a 17-step divider and 6 multiplier steps; then commit and status.
// One item at a time; busy is high until its last result has been issued to the output register. No stall path.
// Reset: synchronous active low; clears size to zero and the controller to idle.
module convex_polygon_plane_clipper import cpc_pkg::*; #(
    parameter int MAX_VERTICES = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_corner_index,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_normal_x,
    input  logic signed [31:0] i_normal_y,
    input  logic signed [31:0] i_normal_z,
    input  logic signed [31:0] i_plane_offset,
    output logic               o_valid,
    output logic [3:0]         o_vertex_index,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic [16:0]        o_weight_b,
    output logic [16:0]        o_weight_c,
    output logic [3:0]         o_vertex_count,
    output logic               o_last
);

    t_cmd  cmd;
    t_stat stat;

    cpc_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    cpc_dpath #(.MAX_VERTICES(MAX_VERTICES)) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_corner_index (i_corner_index),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_normal_x     (i_normal_x),
        .i_normal_y     (i_normal_y),
        .i_normal_z     (i_normal_z),
        .i_plane_offset (i_plane_offset),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_vertex_index (o_vertex_index),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_weight_b     (o_weight_b),
        .o_weight_c     (o_weight_c),
        .o_vertex_count (o_vertex_count),
        .o_last         (o_last)
    );

endmodule
